// File: hw/rtl/priority_ready_queue_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler checker.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRQS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prqs check failed");

// Next-cycle implication, disabled during reset.
`define PRQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prqs check failed");

`endif

// File: hw/rtl/prqs_pkg.sv
// Types, codes and helpers for the priority ready queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

package prqs_pkg;

   // Default sizes
   localparam int NUM_TASKS_DEF      = 8;
   localparam int NUM_PRIORITIES_DEF = 8;
   localparam int MAX_PRIORITIES     = 32;
   localparam int MAX_PW             = $clog2(MAX_PRIORITIES);

   // Command codes
   typedef enum logic [1:0] {
      FUNC_MAKE_READY = 2'd0,
      FUNC_SCHEDULE   = 2'd1,
      FUNC_REMOVE     = 2'd2,
      FUNC_BLOCK      = 2'd3
   } func_type;

   // Result status codes
   localparam logic [1:0] RES_OK        = 2'd0;
   localparam logic [1:0] RES_NOT_FOUND = 2'd1;
   localparam logic [1:0] RES_NO_SWITCH = 2'd2;
   localparam logic [1:0] RES_QUEUED    = 2'd3;

   // Task state codes held in the task table
   localparam logic [1:0] TS_IDLE    = 2'd0;
   localparam logic [1:0] TS_READY   = 2'd2;
   localparam logic [1:0] TS_RUNNING = 2'd3;

   // Shared unit operations
   typedef enum logic [1:0] {
      ALU_INC = 2'd0,
      ALU_DEC = 2'd1,
      ALU_CMP = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic eq;
      logic le;
   } alu_flags_type;

   // Highest set bit of the ready bitmap, zero when empty
   function automatic logic [MAX_PW-1:0] top_of(input logic [MAX_PRIORITIES-1:0] map);
      logic [MAX_PW-1:0] idx;
      idx = '0;
      for (int p = 0; p < MAX_PRIORITIES; p++) begin
         if (map[p]) idx = MAX_PW'(p);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/prqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module prqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read (old data on collision)
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hw/rtl/prqs_alu.sv
// Shared increment, decrement and compare unit of the scheduler sequencer.
`timescale 1ns / 1ps
`default_nettype none

module prqs_alu
   import prqs_pkg::*;
#(
   parameter int W = 4
) (
   input  wire alu_op_type    op,
   input  wire logic [W-1:0]  a,
   input  wire logic [W-1:0]  b,
   output logic      [W-1:0]  res,
   output alu_flags_type      flags
);

   // Arithmetic result
   always_comb begin
      unique case (op)
         ALU_INC: res = a + W'(1);
         ALU_DEC: res = a - W'(1);
         ALU_CMP: res = a;
         default: res = '0;
      endcase
   end

   // Compare flags
   assign flags.eq = (a == b);
   assign flags.le = (a <= b);

endmodule

`default_nettype wire

// File: hw/rtl/priority_ready_queue_scheduler_unit.sv
// Top level of the fixed-priority ready queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

// Fixed-priority task scheduler with one FIFO ready queue per priority level
// and a bitmap of non-empty queues. One request is handled at a time; req_stall
// is high from acceptance until the result is loaded into the output register,
// which holds it while rsp_stall is high so the next request can be taken.
// A result still waiting in the output register holds the next result back.
// The queue links live in a memory with registered read and are walked one
// link per cycle; one shared increment/compare unit serves every count update
// and the priority and task compares of schedule and remove.
module priority_ready_queue_scheduler_unit
   import prqs_pkg::*;
#(
   parameter int NUM_TASKS      = NUM_TASKS_DEF,
   parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_func,
   input  wire logic [2:0] req_task_id,
   input  wire logic [2:0] req_priority_req,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [1:0] rsp_status,
   output logic            rsp_switched,
   output logic      [2:0] rsp_next_task,
   output logic      [2:0] rsp_prev_task,
   output logic      [2:0] rsp_top_priority,
   output logic            rsp_any_ready
);

   localparam int TW  = $clog2(NUM_TASKS);
   localparam int PW  = $clog2(NUM_PRIORITIES);
   localparam int CW  = $clog2(NUM_TASKS + 1);
   localparam int AW0 = (TW > PW) ? TW : PW;
   localparam int AW  = (AW0 > CW) ? AW0 : CW;
   localparam int IW  = 2 + PW;

   // Sequencer states
   typedef enum logic [13:0] {
      S_IDLE        = 14'h0001,
      S_MR_CHECK    = 14'h0002,
      S_APPEND      = 14'h0004,
      S_APPEND_LINK = 14'h0008,
      S_SC_CHECK    = 14'h0010,
      S_SC_HEAD     = 14'h0020,
      S_POP         = 14'h0040,
      S_SW_NEW      = 14'h0080,
      S_RM_CHECK    = 14'h0100,
      S_RM_HEAD     = 14'h0200,
      S_RM_WALK     = 14'h0400,
      S_RM_FIX      = 14'h0800,
      S_RM_COUNT    = 14'h1000,
      S_DONE        = 14'h2000
   } state_type;

   state_type state_ff, state_in;

   // Request context
   func_type        func_ff, func_in;
   logic [TW-1:0]   tid_ff, tid_in;
   logic            oor_ff, oor_in;
   logic [PW-1:0]   preq_ff, preq_in;
   logic [TW-1:0]   prev_ff, prev_in;
   logic [1:0]      res_ff, res_in;
   logic            sw_ff, sw_in;

   // Running task
   logic [TW-1:0]   running_ff, running_in;
   logic [PW-1:0]   run_prio_ff, run_prio_in;
   logic            run_blocked_ff, run_blocked_in;

   // Working registers
   logic [PW-1:0]   qp_ff, qp_in;
   logic [TW-1:0]   app_ff, app_in;
   logic [TW-1:0]   cur_ff, cur_in;

   // Queue descriptors
   logic [TW-1:0]   head_ff  [NUM_PRIORITIES];
   logic [TW-1:0]   head_in  [NUM_PRIORITIES];
   logic [TW-1:0]   tail_ff  [NUM_PRIORITIES];
   logic [TW-1:0]   tail_in  [NUM_PRIORITIES];
   logic [CW-1:0]   count_ff [NUM_PRIORITIES];
   logic [CW-1:0]   count_in [NUM_PRIORITIES];
   logic [NUM_PRIORITIES-1:0] bitmap_ff, bitmap_in;

   // Task table valid bits and read address
   logic [NUM_TASKS-1:0] info_valid_ff, info_valid_in;
   logic [TW-1:0]   info_ra_ff, info_ra_in;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic            rsp_switched_ff, rsp_switched_in;
   logic [2:0]      rsp_next_ff, rsp_next_in;
   logic [2:0]      rsp_prev_ff, rsp_prev_in;
   logic [2:0]      rsp_top_ff, rsp_top_in;
   logic            rsp_any_ff, rsp_any_in;

   // Memory ports
   logic            link_we;
   logic [TW-1:0]   link_waddr, link_wdata, link_raddr, link_rdata;
   logic            info_we;
   logic [TW-1:0]   info_waddr;
   logic [IW-1:0]   info_wdata, info_rdata, info_rd;
   logic [1:0]      info_stat;
   logic [PW-1:0]   info_prio;

   // Shared unit
   alu_op_type      alu_op;
   logic [AW-1:0]   alu_a, alu_b, alu_res;
   alu_flags_type   alu_flags;

   logic [PW-1:0]   top_now;
   logic            rsp_free;

   // Queue links
   prqs_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   // Task state and priority, read at the request's task
   prqs_ram #(.WIDTH(IW), .DEPTH(NUM_TASKS)) u_info_ram (
      .clock (clock),
      .we    (info_we),
      .waddr (info_waddr),
      .wdata (info_wdata),
      .raddr (TW'(req_task_id)),
      .rdata (info_rdata)
   );

   prqs_alu #(.W(AW)) u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .res   (alu_res),
      .flags (alu_flags)
   );

   // Unwritten table entries read as their reset value
   always_comb begin
      if (info_valid_ff[info_ra_ff]) begin
         info_rd = info_rdata;
      end else begin
         info_rd = {((info_ra_ff == TW'(0)) ? TS_RUNNING : TS_IDLE), PW'(0)};
      end
   end
   assign info_stat = info_rd[IW-1 -: 2];
   assign info_prio = info_rd[PW-1:0];

   assign top_now    = PW'(top_of(MAX_PRIORITIES'(bitmap_ff)));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign link_raddr = (state_ff == S_RM_WALK) ? link_rdata : head_ff[qp_ff];

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      func_in         = func_ff;
      tid_in          = tid_ff;
      oor_in          = oor_ff;
      preq_in         = preq_ff;
      prev_in         = prev_ff;
      res_in          = res_ff;
      sw_in           = sw_ff;
      running_in      = running_ff;
      run_prio_in     = run_prio_ff;
      run_blocked_in  = run_blocked_ff;
      qp_in           = qp_ff;
      app_in          = app_ff;
      cur_in          = cur_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      bitmap_in       = bitmap_ff;
      info_valid_in   = info_valid_ff;
      info_ra_in      = info_ra_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_next_in     = rsp_next_ff;
      rsp_prev_in     = rsp_prev_ff;
      rsp_top_in      = rsp_top_ff;
      rsp_any_in      = rsp_any_ff;
      link_we         = 1'b0;
      link_waddr      = app_ff;
      link_wdata      = TW'(0);
      info_we         = 1'b0;
      info_waddr      = tid_ff;
      info_wdata      = {TS_READY, preq_ff};
      alu_op          = ALU_CMP;
      alu_a           = AW'(0);
      alu_b           = AW'(0);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in    = func_type'(req_func);
               tid_in     = TW'(req_task_id);
               oor_in     = (int'(req_task_id) >= NUM_TASKS);
               preq_in    = (int'(req_priority_req) >= NUM_PRIORITIES) ?
                            PW'(NUM_PRIORITIES - 1) : PW'(req_priority_req);
               prev_in    = running_ff;
               res_in     = RES_OK;
               sw_in      = 1'b0;
               info_ra_in = TW'(req_task_id);
               unique case (func_type'(req_func))
                  FUNC_MAKE_READY: state_in = S_MR_CHECK;
                  FUNC_SCHEDULE:   state_in = S_SC_CHECK;
                  FUNC_REMOVE:     state_in = S_RM_CHECK;
                  FUNC_BLOCK: begin
                     run_blocked_in = 1'b1;
                     state_in       = S_DONE;
                  end
                  default:         state_in = S_DONE;
               endcase
            end
         end

         // Make ready: reject bad, queued or running tasks
         S_MR_CHECK: begin
            priority if (oor_ff) begin
               res_in   = RES_NOT_FOUND;
               state_in = S_DONE;
            end else if (info_stat == TS_READY || tid_ff == running_ff) begin
               res_in   = RES_QUEUED;
               state_in = S_DONE;
            end else begin
               info_we    = 1'b1;
               info_waddr = tid_ff;
               info_wdata = {TS_READY, preq_ff};
               qp_in      = preq_ff;
               app_in     = tid_ff;
               state_in   = S_APPEND;
            end
         end

         // Append at the tail of queue qp
         S_APPEND: begin
            alu_op            = ALU_INC;
            alu_a             = AW'(count_ff[qp_ff]);
            count_in[qp_ff]   = CW'(alu_res);
            tail_in[qp_ff]    = app_ff;
            bitmap_in[qp_ff]  = 1'b1;
            link_we           = 1'b1;
            link_waddr        = app_ff;
            link_wdata        = TW'(0);
            if (count_ff[qp_ff] == CW'(0)) begin
               head_in[qp_ff] = app_ff;
               state_in       = (func_ff == FUNC_SCHEDULE) ? S_SW_NEW : S_DONE;
            end else begin
               cur_in   = tail_ff[qp_ff];
               state_in = S_APPEND_LINK;
            end
         end

         // Link the old tail to the new one
         S_APPEND_LINK: begin
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = app_ff;
            state_in   = (func_ff == FUNC_SCHEDULE) ? S_SW_NEW : S_DONE;
         end

         // Schedule: compare top level against the running priority
         S_SC_CHECK: begin
            alu_op = ALU_CMP;
            alu_a  = AW'(run_prio_ff);
            alu_b  = AW'(top_now);
            if (bitmap_ff == '0 || !alu_flags.le) begin
               res_in   = RES_NO_SWITCH;
               state_in = S_DONE;
            end else begin
               qp_in    = top_now;
               state_in = S_SC_HEAD;
            end
         end

         // Head link read in flight
         S_SC_HEAD: begin
            state_in = S_POP;
         end

         // Pop the head of queue qp
         S_POP: begin
            alu_op          = ALU_DEC;
            alu_a           = AW'(count_ff[qp_ff]);
            count_in[qp_ff] = CW'(alu_res);
            head_in[qp_ff]  = link_rdata;
            if (CW'(alu_res) == CW'(0)) bitmap_in[qp_ff] = 1'b0;
            if (func_ff == FUNC_REMOVE) begin
               state_in = S_DONE;
            end else begin
               running_in     = head_ff[qp_ff];
               run_prio_in    = qp_ff;
               run_blocked_in = 1'b0;
               sw_in          = 1'b1;
               if (!run_blocked_ff) begin
                  info_we    = 1'b1;
                  info_waddr = running_ff;
                  info_wdata = {TS_READY, run_prio_ff};
                  qp_in      = run_prio_ff;
                  app_in     = running_ff;
                  state_in   = S_APPEND;
               end else begin
                  state_in   = S_SW_NEW;
               end
            end
         end

         // Mark the new running task
         S_SW_NEW: begin
            info_we    = 1'b1;
            info_waddr = running_ff;
            info_wdata = {TS_RUNNING, run_prio_ff};
            state_in   = S_DONE;
         end

         // Remove: task must be waiting in a queue
         S_RM_CHECK: begin
            if (oor_ff || info_stat != TS_READY) begin
               res_in   = RES_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               info_we    = 1'b1;
               info_waddr = tid_ff;
               info_wdata = {TS_IDLE, info_prio};
               qp_in      = info_prio;
               state_in   = S_RM_HEAD;
            end
         end

         // Head match means a plain pop
         S_RM_HEAD: begin
            alu_op = ALU_CMP;
            alu_a  = AW'(head_ff[qp_ff]);
            alu_b  = AW'(tid_ff);
            if (alu_flags.eq) begin
               state_in = S_POP;
            end else begin
               cur_in   = head_ff[qp_ff];
               state_in = S_RM_WALK;
            end
         end

         // One link per cycle until the successor is the task
         S_RM_WALK: begin
            alu_op = ALU_CMP;
            alu_a  = AW'(link_rdata);
            alu_b  = AW'(tid_ff);
            if (alu_flags.eq) begin
               state_in = S_RM_FIX;
            end else begin
               cur_in = link_rdata;
            end
         end

         // Bridge over the task, pull back the tail if needed
         S_RM_FIX: begin
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = link_rdata;
            alu_op     = ALU_CMP;
            alu_a      = AW'(tail_ff[qp_ff]);
            alu_b      = AW'(tid_ff);
            if (alu_flags.eq) tail_in[qp_ff] = cur_ff;
            state_in   = S_RM_COUNT;
         end

         S_RM_COUNT: begin
            alu_op          = ALU_DEC;
            alu_a           = AW'(count_ff[qp_ff]);
            count_in[qp_ff] = CW'(alu_res);
            state_in        = S_DONE;
         end

         // Load the result once the output register is free
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_ff;
               rsp_switched_in = sw_ff;
               rsp_next_in     = 3'(running_ff);
               rsp_prev_in     = 3'(prev_ff);
               rsp_top_in      = 3'(top_now);
               rsp_any_in      = (bitmap_ff != '0);
               state_in        = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (info_we) info_valid_in[info_waddr] = 1'b1;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         running_ff     <= TW'(0);
         run_prio_ff    <= PW'(0);
         run_blocked_ff <= 1'b0;
         bitmap_ff      <= '0;
         info_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int p = 0; p < NUM_PRIORITIES; p++) count_ff[p] <= CW'(0);
      end else begin
         state_ff       <= state_in;
         running_ff     <= running_in;
         run_prio_ff    <= run_prio_in;
         run_blocked_ff <= run_blocked_in;
         bitmap_ff      <= bitmap_in;
         info_valid_ff  <= info_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      tid_ff          <= tid_in;
      oor_ff          <= oor_in;
      preq_ff         <= preq_in;
      prev_ff         <= prev_in;
      res_ff          <= res_in;
      sw_ff           <= sw_in;
      qp_ff           <= qp_in;
      app_ff          <= app_in;
      cur_ff          <= cur_in;
      head_ff         <= head_in;
      tail_ff         <= tail_in;
      info_ra_ff      <= info_ra_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_next_ff     <= rsp_next_in;
      rsp_prev_ff     <= rsp_prev_in;
      rsp_top_ff      <= rsp_top_in;
      rsp_any_ff      <= rsp_any_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_switched     = rsp_switched_ff;
   assign rsp_next_task    = rsp_next_ff;
   assign rsp_prev_task    = rsp_prev_ff;
   assign rsp_top_priority = rsp_top_ff;
   assign rsp_any_ready    = rsp_any_ff;

endmodule

`default_nettype wire

// File: hw/rtl/prqs_checker.sv
// Port-level checks of the scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "priority_ready_queue_scheduler_unit_defines.svh"

module prqs_checker
   import prqs_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_switched,
   input wire logic [2:0] rsp_next_task,
   input wire logic [2:0] rsp_prev_task,
   input wire logic [2:0] rsp_top_priority,
   input wire logic       rsp_any_ready
);

   // One request at a time: busy right after acceptance
   `PRQS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A switch always reports success
   `PRQS_ASSERT_IMPLIES(a_switch_ok, clock, reset, rsp_valid && rsp_switched, rsp_status == RES_OK)

   // Without a switch the running task is unchanged
   `PRQS_ASSERT_IMPLIES(a_no_switch_same, clock, reset, rsp_valid && !rsp_switched, rsp_next_task == rsp_prev_task)

   // Empty bitmap reports level zero
   `PRQS_ASSERT_IMPLIES(a_empty_top_zero, clock, reset, rsp_valid && !rsp_any_ready, rsp_top_priority == 3'd0)

   // Stalled result holds
   `PRQS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_next_task))

endmodule

bind priority_ready_queue_scheduler_unit prqs_checker u_prqs_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the priority ready queue scheduler unit.
`timescale 1ns / 1ps
module tb_top;
   import prqs_pkg::*;

   localparam int NTASK            = NUM_TASKS_DEF;
   localparam int NPRIO            = NUM_PRIORITIES_DEF;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int DRAIN_CYCLES     = NUM_TASKS_DEF + 12;
   localparam int RANDOM_PER_PHASE = 282;

   // Task states held by the predictor
   typedef enum logic [1:0] {
      TASK_IDLE    = 2'd0,
      TASK_BLOCKED = 2'd1,
      TASK_READY   = 2'd2,
      TASK_RUNNING = 2'd3
   } task_state_type;

   // One scheduler response, field order as on the rsp_ ports
   typedef struct packed {
      logic [1:0] status;
      logic       switched;
      logic [2:0] next_task;
      logic [2:0] prev_task;
      logic [2:0] top_priority;
      logic       any_ready;
   } sched_result_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [1:0] req_func         = FUNC_MAKE_READY;
   logic [2:0] req_task_id      = '0;
   logic [2:0] req_priority_req = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_switched;
   logic [2:0] rsp_next_task;
   logic [2:0] rsp_prev_task;
   logic [2:0] rsp_top_priority;
   logic       rsp_any_ready;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int error_count   = 0;
   int idle_cycles   = 0;

   sched_result_type pending_results [$];

   // Predictor copy of the scheduler state
   logic [2:0]     cur_running;
   task_state_type task_state [NTASK];
   logic [2:0]     task_prio  [NTASK];
   logic [2:0]     link_of    [NTASK];
   logic [2:0]     q_head     [NPRIO];
   logic [2:0]     q_tail     [NPRIO];
   int             q_count    [NPRIO];
   logic [NPRIO-1:0] ready_map;

   priority_ready_queue_scheduler_unit #(
      .NUM_TASKS      (NTASK),
      .NUM_PRIORITIES (NPRIO)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_switched     (rsp_switched),
      .rsp_next_task    (rsp_next_task),
      .rsp_prev_task    (rsp_prev_task),
      .rsp_top_priority (rsp_top_priority),
      .rsp_any_ready    (rsp_any_ready)
   );

   // Clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor queue helpers
   function automatic void enqueue_task(logic [2:0] t, int p);
      if (q_count[p] > 0) link_of[q_tail[p]] = t;
      else q_head[p] = t;
      q_tail[p]    = t;
      link_of[t]   = '0;
      q_count[p]   = q_count[p] + 1;
      ready_map[p] = 1'b1;
   endfunction

   function automatic logic [2:0] dequeue_head(int p);
      logic [2:0] t;
      t         = q_head[p];
      q_head[p] = link_of[t];
      if (q_count[p] <= 1) begin
         q_count[p]   = 0;
         ready_map[p] = 1'b0;
      end else begin
         q_count[p] = q_count[p] - 1;
      end
      return t;
   endfunction

   // Walks the links of queue p and drops task t
   function automatic void unlink_task(logic [2:0] t, int p);
      logic [2:0] cur;
      logic [2:0] nx;
      if (q_count[p] == 0) return;
      if (q_head[p] == t) begin
         void'(dequeue_head(p));
         return;
      end
      cur = q_head[p];
      for (int i = 1; i < q_count[p]; i++) begin
         nx = link_of[cur];
         if (nx == t) begin
            link_of[cur] = link_of[nx];
            if (q_tail[p] == t) q_tail[p] = cur;
            q_count[p] = q_count[p] - 1;
            return;
         end
         cur = nx;
      end
   endfunction

   function automatic logic [2:0] highest_ready();
      logic [2:0] top;
      top = '0;
      for (int p = 0; p < NPRIO; p++) begin
         if (ready_map[p]) top = p[2:0];
      end
      return top;
   endfunction

   // Applies one request to the predictor and returns the response it causes
   function automatic sched_result_type predict_scheduler(func_type f, logic [2:0] tid,
                                                          logic [2:0] prio);
      sched_result_type r;
      logic [2:0] top;
      logic [2:0] old_task;
      logic [2:0] new_task;
      logic [2:0] run_prio;
      r.status    = RES_OK;
      r.switched  = 1'b0;
      r.prev_task = cur_running;
      case (f)
         FUNC_MAKE_READY: begin
            if (task_state[tid] == TASK_READY || tid == cur_running) begin
               r.status = RES_QUEUED;
            end else begin
               task_prio[tid]  = prio;
               task_state[tid] = TASK_READY;
               enqueue_task(tid, prio);
            end
         end
         FUNC_SCHEDULE: begin
            if (ready_map == '0) begin
               r.status = RES_NO_SWITCH;
            end else begin
               top      = highest_ready();
               run_prio = task_prio[cur_running];
               if (run_prio <= top) begin
                  new_task = dequeue_head(top);
                  old_task = cur_running;
                  // a blocked task is not put back on its queue
                  if (task_state[old_task] != TASK_BLOCKED) begin
                     task_state[old_task] = TASK_READY;
                     enqueue_task(old_task, run_prio);
                  end
                  task_state[new_task] = TASK_RUNNING;
                  cur_running          = new_task;
                  r.switched           = 1'b1;
               end else begin
                  r.status = RES_NO_SWITCH;
               end
            end
         end
         FUNC_REMOVE: begin
            if (task_state[tid] != TASK_READY) begin
               r.status = RES_NOT_FOUND;
            end else begin
               unlink_task(tid, task_prio[tid]);
               task_state[tid] = TASK_IDLE;
            end
         end
         default: task_state[cur_running] = TASK_BLOCKED;
      endcase
      r.next_task    = cur_running;
      r.top_priority = highest_ready();
      r.any_ready    = |ready_map;
      return r;
   endfunction

   // Sends one request, with random gaps, and records its expected response
   task automatic send_request(func_type f, logic [2:0] tid, logic [2:0] prio);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_task_id      <= tid;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_scheduler(f, tid, prio));
   endtask

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Response checker
   always @(posedge clock) begin : check_response
      sched_result_type exp_r;
      sched_result_type got_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_r = {rsp_status, rsp_switched, rsp_next_task, rsp_prev_task,
                  rsp_top_priority, rsp_any_ready};
         if (pending_results.size() == 0) begin
            $display("%0t: response with none expected: status %0d next %0d prev %0d",
                     $time, got_r.status, got_r.next_task, got_r.prev_task);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (got_r !== exp_r) begin
               $display("%0t: mismatch expected status %0d sw %0d next %0d prev %0d top %0d any %0d",
                        $time, exp_r.status, exp_r.switched, exp_r.next_task,
                        exp_r.prev_task, exp_r.top_priority, exp_r.any_ready);
               $display("%0t:          actual   status %0d sw %0d next %0d prev %0d top %0d any %0d",
                        $time, got_r.status, got_r.switched, got_r.next_task,
                        got_r.prev_task, got_r.top_priority, got_r.any_ready);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL priority_ready_queue_scheduler_unit");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Empty schedule, make ready of the running and of a queued task
   task automatic test_make_ready_cases();
      send_request(FUNC_SCHEDULE, 3'd0, 3'd0);
      send_request(FUNC_MAKE_READY, 3'd0, 3'd3);
      send_request(FUNC_MAKE_READY, 3'd1, 3'd7);
      send_request(FUNC_MAKE_READY, 3'd1, 3'd3);
      send_request(FUNC_MAKE_READY, 3'd2, 3'd7);
      send_request(FUNC_MAKE_READY, 3'd3, 3'd0);
   endtask

   // Removal of idle, tail, head and middle tasks
   task automatic test_remove_cases();
      send_request(FUNC_REMOVE, 3'd5, 3'd0);
      send_request(FUNC_REMOVE, 3'd2, 3'd0);
      send_request(FUNC_REMOVE, 3'd1, 3'd7);
      send_request(FUNC_MAKE_READY, 3'd4, 3'd5);
      send_request(FUNC_MAKE_READY, 3'd5, 3'd5);
      send_request(FUNC_MAKE_READY, 3'd6, 3'd5);
      send_request(FUNC_REMOVE, 3'd5, 3'd0);
      send_request(FUNC_REMOVE, 3'd5, 3'd0);
   endtask

   // Switches with requeue, and no switch on a lower top priority
   task automatic test_schedule_cases();
      send_request(FUNC_SCHEDULE, 3'd7, 3'd7);
      send_request(FUNC_SCHEDULE, 3'd0, 3'd0);
      send_request(FUNC_SCHEDULE, 3'd0, 3'd0);
      send_request(FUNC_REMOVE, 3'd6, 3'd0);
      send_request(FUNC_SCHEDULE, 3'd0, 3'd0);
   endtask

   // Blocked running task: held, not requeued on switch, then made ready
   task automatic test_block_cases();
      send_request(FUNC_BLOCK, 3'd0, 3'd0);
      send_request(FUNC_MAKE_READY, 3'd4, 3'd1);
      send_request(FUNC_SCHEDULE, 3'd0, 3'd0);
      send_request(FUNC_MAKE_READY, 3'd7, 3'd7);
      send_request(FUNC_SCHEDULE, 3'd0, 3'd0);
      send_request(FUNC_MAKE_READY, 3'd4, 3'd2);
      send_request(FUNC_REMOVE, 3'd7, 3'd0);
   endtask

   // Random command mix; removals mostly aim at queued tasks
   task automatic test_random_traffic(int n);
      int         sel;
      logic [2:0] tid;
      logic [2:0] prio;
      logic [2:0] queued_ids [$];
      for (int i = 0; i < n; i++) begin
         sel  = $urandom_range(99);
         tid  = 3'($urandom_range(NTASK - 1));
         prio = 3'($urandom_range(NPRIO - 1));
         if (sel < 35) begin
            send_request(FUNC_MAKE_READY, tid, prio);
         end else if (sel < 65) begin
            send_request(FUNC_SCHEDULE, tid, prio);
         end else if (sel < 85) begin
            queued_ids = {};
            for (int t = 0; t < NTASK; t++) begin
               if (task_state[t] == TASK_READY) queued_ids.push_back(t[2:0]);
            end
            if (queued_ids.size() > 0 && $urandom_range(3) != 0)
               tid = queued_ids[$urandom_range(queued_ids.size() - 1)];
            send_request(FUNC_REMOVE, tid, prio);
         end else begin
            send_request(FUNC_BLOCK, tid, prio);
         end
      end
   endtask

   initial begin
      // predictor reset state
      cur_running = '0;
      ready_map   = '0;
      for (int t = 0; t < NTASK; t++) begin
         task_state[t] = TASK_IDLE;
         task_prio[t]  = '0;
         link_of[t]    = '0;
      end
      task_state[0] = TASK_RUNNING;
      for (int p = 0; p < NPRIO; p++) begin
         q_head[p]  = '0;
         q_tail[p]  = '0;
         q_count[p] = 0;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_make_ready_cases();
      test_remove_cases();
      test_schedule_cases();
      test_block_cases();

      // idling phases
      send_idle_pct = 0;  stall_pct = 0;
      test_random_traffic(RANDOM_PER_PHASE);
      send_idle_pct = 71; stall_pct = 0;
      test_random_traffic(RANDOM_PER_PHASE);
      send_idle_pct = 0;  stall_pct = 71;
      test_random_traffic(RANDOM_PER_PHASE);
      send_idle_pct = 34; stall_pct = 34;
      test_random_traffic(RANDOM_PER_PHASE);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS priority_ready_queue_scheduler_unit");
      end else begin
         $display("FAIL priority_ready_queue_scheduler_unit");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/prqs_pkg.sv
hw/rtl/prqs_ram.sv
hw/rtl/prqs_alu.sv
hw/rtl/priority_ready_queue_scheduler_unit.sv
hw/rtl/prqs_checker.sv
verif/tb_top.sv
